@@ hdl/ehc_pkg.sv @@
// Shared types, ELF codes and the header field layout for the ELF64 header checker.
`timescale 1ns / 1ps
`default_nettype none

package ehc_pkg;

    // Header geometry.
    localparam int HdrBytes = 64;
    localparam int OffsetW  = $clog2(HdrBytes) + 1;

    typedef logic [OffsetW-1:0] offset_t;
    typedef logic [4:0]         field_id_t;

    // Field identifiers in header order.
    localparam field_id_t FID_MAGIC     = 5'd0;
    localparam field_id_t FID_CLASS     = 5'd1;
    localparam field_id_t FID_DATA      = 5'd2;
    localparam field_id_t FID_IDENTVER  = 5'd3;
    localparam field_id_t FID_OSABI     = 5'd4;
    localparam field_id_t FID_ABIVER    = 5'd5;
    localparam field_id_t FID_TYPE      = 5'd6;
    localparam field_id_t FID_MACHINE   = 5'd7;
    localparam field_id_t FID_VERSION   = 5'd8;
    localparam field_id_t FID_ENTRY     = 5'd9;
    localparam field_id_t FID_PHOFF     = 5'd10;
    localparam field_id_t FID_SHOFF     = 5'd11;
    localparam field_id_t FID_FLAGS     = 5'd12;
    localparam field_id_t FID_EHSIZE    = 5'd13;
    localparam field_id_t FID_PHENTSIZE = 5'd14;
    localparam field_id_t FID_PHNUM     = 5'd15;
    localparam field_id_t FID_SHENTSIZE = 5'd16;
    localparam field_id_t FID_SHNUM     = 5'd17;
    localparam field_id_t FID_SHSTRNDX  = 5'd18;

    // Status codes reported with each field.
    typedef enum logic [3:0] {
        ST_OK                = 4'd0,
        ST_BAD_MAGIC         = 4'd1,
        ST_UNKNOWN_CLASS     = 4'd2,
        ST_CLASS_UNSUPPORTED = 4'd3,
        ST_UNKNOWN_DATA      = 4'd4,
        ST_DATA_UNSUPPORTED  = 4'd5,
        ST_BAD_VERSION       = 4'd6,
        ST_UNKNOWN_TYPE      = 4'd7,
        ST_UNKNOWN_MACHINE   = 4'd8
    } status_t;

    // Identification bytes.
    localparam logic [7:0] MAGIC_0 = 8'h7F;
    localparam logic [7:0] MAGIC_1 = 8'h45;
    localparam logic [7:0] MAGIC_2 = 8'h4C;
    localparam logic [7:0] MAGIC_3 = 8'h46;

    localparam logic [7:0] CLASS_32   = 8'd1;
    localparam logic [7:0] CLASS_64   = 8'd2;
    localparam logic [7:0] DATA_LSB   = 8'd1;
    localparam logic [7:0] DATA_MSB   = 8'd2;
    localparam logic [7:0] IDENT_CUR  = 8'd1;
    localparam logic [31:0] VERSION_CUR = 32'd1;

    // File types.
    localparam logic [15:0] TYPE_REL  = 16'd1;
    localparam logic [15:0] TYPE_CORE = 16'd4;

    // Known machines.
    localparam logic [15:0] MACH_SPARC   = 16'd2;
    localparam logic [15:0] MACH_386     = 16'd3;
    localparam logic [15:0] MACH_MIPS    = 16'd8;
    localparam logic [15:0] MACH_PPC     = 16'd20;
    localparam logic [15:0] MACH_ARM     = 16'd40;
    localparam logic [15:0] MACH_SH      = 16'd42;
    localparam logic [15:0] MACH_IA64    = 16'd50;
    localparam logic [15:0] MACH_X86_64  = 16'd62;
    localparam logic [15:0] MACH_AARCH64 = 16'd183;

    // Field length in bytes.
    typedef enum logic [1:0] {
        LEN_1,
        LEN_2,
        LEN_4,
        LEN_8
    } field_len_t;

    // What ends at a given header offset.
    typedef struct packed {
        logic       hit;
        field_id_t  id;
        field_len_t len;
    } field_end_t;

    // Returns the field whose last byte sits at this offset, if any.
    function automatic field_end_t field_end(input logic [OffsetW-2:0] off);
        field_end_t fe;
        case (off)
            6'd3:    fe = '{1'b1, FID_MAGIC,     LEN_4};
            6'd4:    fe = '{1'b1, FID_CLASS,     LEN_1};
            6'd5:    fe = '{1'b1, FID_DATA,      LEN_1};
            6'd6:    fe = '{1'b1, FID_IDENTVER,  LEN_1};
            6'd7:    fe = '{1'b1, FID_OSABI,     LEN_1};
            6'd8:    fe = '{1'b1, FID_ABIVER,    LEN_1};
            6'd17:   fe = '{1'b1, FID_TYPE,      LEN_2};
            6'd19:   fe = '{1'b1, FID_MACHINE,   LEN_2};
            6'd23:   fe = '{1'b1, FID_VERSION,   LEN_4};
            6'd31:   fe = '{1'b1, FID_ENTRY,     LEN_8};
            6'd39:   fe = '{1'b1, FID_PHOFF,     LEN_8};
            6'd47:   fe = '{1'b1, FID_SHOFF,     LEN_8};
            6'd51:   fe = '{1'b1, FID_FLAGS,     LEN_4};
            6'd53:   fe = '{1'b1, FID_EHSIZE,    LEN_2};
            6'd55:   fe = '{1'b1, FID_PHENTSIZE, LEN_2};
            6'd57:   fe = '{1'b1, FID_PHNUM,     LEN_2};
            6'd59:   fe = '{1'b1, FID_SHENTSIZE, LEN_2};
            6'd61:   fe = '{1'b1, FID_SHNUM,     LEN_2};
            6'd63:   fe = '{1'b1, FID_SHSTRNDX,  LEN_2};
            default: fe = '{1'b0, FID_MAGIC,     LEN_1};
        endcase
        return fe;
    endfunction

    // Expected magic byte at offsets zero to three.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = MAGIC_0;
            2'd1:    b = MAGIC_1;
            2'd2:    b = MAGIC_2;
            default: b = MAGIC_3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hdl/elf64_header_checker.sv @@
// Top level of the ELF64 header checker: byte parser, field checks and output skid stage.
`timescale 1ns / 1ps
`default_nettype none

// Takes an ELF64 file header one byte per transfer and reports each header
// field once its last byte is in, with the field id, its little-endian value
// and a status. A byte is taken in every cycle while byte_stall is low; parsing
// and checking are combinational logic behind the parser state registers, and
// each result is registered. Results leave through an output register backed
// by a one-entry skid register, so bytes keep flowing while a result waits;
// byte_stall rises only when both are full. The first error, or the last field,
// raises header_done and the parser then ignores bytes until one arrives with
// first_byte set. After reset the first byte counts as offset zero.
module elf64_header_checker (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    byte_valid,
    output logic                   byte_stall,
    input  wire  [7:0]             data_byte,
    input  wire                    first_byte,
    output logic                   field_valid,
    input  wire                    field_stall,
    output ehc_pkg::field_id_t     field_id,
    output logic [63:0]            field_value,
    output logic [3:0]             status,
    output logic                   header_done
);
    import ehc_pkg::*;

    typedef struct packed {
        field_id_t   id;
        logic [63:0] value;
        status_t     st;
        logic        done;
    } result_t;

    // Parser state.
    offset_t     byte_offset_reg, byte_offset_next;
    logic [63:0] field_acc_reg, field_acc_next;
    logic        magic_ok_reg, magic_ok_next;
    logic        stopped_reg, stopped_next;

    // Output register and skid register.
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    // Values after an optional restart.
    offset_t     off_cur;
    logic [63:0] acc_cur;
    logic        magic_cur;
    logic        stopped_cur;

    logic        idle;
    logic [63:0] acc_shift;
    field_end_t  fe;
    logic        magic_hit;
    logic        magic_new;
    logic [63:0] value;
    status_t     st;
    logic        done;
    logic        produce;
    result_t     res;
    logic        in_xfer;
    logic        out_xfer;

    // A restart makes this byte offset zero of a fresh header.
    always_comb
    begin
        off_cur     = first_byte ? '0 : byte_offset_reg;
        acc_cur     = first_byte ? '0 : field_acc_reg;
        magic_cur   = first_byte ? 1'b1 : magic_ok_reg;
        stopped_cur = first_byte ? 1'b0 : stopped_reg;
    end

    // Shift the byte in and find the field that ends here.
    always_comb
    begin
        idle      = stopped_cur || off_cur[OffsetW-1];
        acc_shift = {data_byte, acc_cur[63:8]};
        fe        = field_end(off_cur[OffsetW-2:0]);
        magic_hit = (off_cur[OffsetW-1:2] != '0)
                    || (data_byte == magic_byte(off_cur[1:0]));
        magic_new = magic_cur && magic_hit;
    end

    // The completed field sits at the top of the accumulator.
    always_comb
    begin
        case (fe.len)
            LEN_1:   value = {56'd0, acc_shift[63:56]};
            LEN_2:   value = {48'd0, acc_shift[63:48]};
            LEN_4:   value = {32'd0, acc_shift[63:32]};
            LEN_8:   value = acc_shift;
            default: value = acc_shift;
        endcase
    end

    // Field checks against the standard codes.
    always_comb
    begin
        case (fe.id)
            FID_MAGIC:
                st = magic_new ? ST_OK : ST_BAD_MAGIC;
            FID_CLASS:
                if (value[7:0] == CLASS_64)
                    st = ST_OK;
                else if (value[7:0] == CLASS_32)
                    st = ST_CLASS_UNSUPPORTED;
                else
                    st = ST_UNKNOWN_CLASS;
            FID_DATA:
                if (value[7:0] == DATA_LSB)
                    st = ST_OK;
                else if (value[7:0] == DATA_MSB)
                    st = ST_DATA_UNSUPPORTED;
                else
                    st = ST_UNKNOWN_DATA;
            FID_IDENTVER:
                st = (value[7:0] == IDENT_CUR) ? ST_OK : ST_BAD_VERSION;
            FID_TYPE:
                st = (value[15:0] inside {[TYPE_REL:TYPE_CORE]}) ? ST_OK : ST_UNKNOWN_TYPE;
            FID_MACHINE:
                st = (value[15:0] inside {MACH_SPARC, MACH_386, MACH_MIPS, MACH_PPC,
                                          MACH_ARM, MACH_SH, MACH_IA64, MACH_X86_64,
                                          MACH_AARCH64}) ? ST_OK : ST_UNKNOWN_MACHINE;
            FID_VERSION:
                st = (value[31:0] == VERSION_CUR) ? ST_OK : ST_BAD_VERSION;
            default:
                st = ST_OK;
        endcase
        done    = (st != ST_OK) || (fe.id == FID_SHSTRNDX);
        produce = !idle && fe.hit;
        res     = '{fe.id, value, st, done};
    end

    // Handshakes. Input stalls only while the skid register holds a result.
    always_comb
    begin
        byte_stall = skid_valid_reg;
        in_xfer    = byte_valid && !skid_valid_reg;
        out_xfer   = out_valid_reg && !field_stall;
    end

    // Next parser state for an accepted byte.
    always_comb
    begin
        byte_offset_next = byte_offset_reg;
        field_acc_next   = field_acc_reg;
        magic_ok_next    = magic_ok_reg;
        stopped_next     = stopped_reg;
        if (in_xfer)
        begin
            if (idle)
            begin
                byte_offset_next = off_cur;
                field_acc_next   = acc_cur;
                magic_ok_next    = magic_cur;
                stopped_next     = 1'b1;
            end
            else
            begin
                byte_offset_next = off_cur + offset_t'(1);
                field_acc_next   = fe.hit ? '0 : acc_shift;
                magic_ok_next    = magic_new;
                stopped_next     = produce && done;
            end
        end
    end

    // Output register and skid register steering.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_xfer && produce)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= '0;
            field_acc_reg   <= '0;
            magic_ok_reg    <= 1'b1;
            stopped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_offset_reg <= byte_offset_next;
            field_acc_reg   <= field_acc_next;
            magic_ok_reg    <= magic_ok_next;
            stopped_reg     <= stopped_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Output ports.
    assign field_valid = out_valid_reg;
    assign field_id    = out_reg.id;
    assign field_value = out_reg.value;
    assign status      = out_reg.st;
    assign header_done = out_reg.done;

endmodule

`default_nettype wire

@@ hdl/ehc_checker.sv @@
// Port-level assertions for the ELF64 header checker and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module ehc_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 field_valid,
    input wire                 field_stall,
    input wire ehc_pkg::field_id_t field_id,
    input wire [63:0]          field_value,
    input wire [3:0]           status,
    input wire                 header_done
);
    import ehc_pkg::*;

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_stall |=> field_valid && $stable(field_id)
            && $stable(field_value) && $stable(status) && $stable(header_done))
        else $error("result changed while stalled");

    // Field ids stay within the header layout.
    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid |-> field_id <= FID_SHSTRNDX)
        else $error("field id out of range");

    // Any error ends the header.
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && status != ST_OK |-> header_done)
        else $error("error without header_done");

    // A clean end happens only on the last field.
    a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && header_done && status == ST_OK |-> field_id == FID_SHSTRNDX)
        else $error("header ended early without error");

    // The magic field reports only a magic status.
    a_magic_status: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_id == FID_MAGIC |-> status == ST_OK || status == ST_BAD_MAGIC)
        else $error("wrong status on magic field");

endmodule

bind elf64_header_checker ehc_checker u_ehc_checker (.*);

`default_nettype wire
